### rtl/ffelim_pkg.sv
// Shared types and constants for the force-free E-field magnitude limiter.
// Used by the limiter top level and its port checker.
package ffelim_pkg;

   localparam int FIELD_W = 32;
   localparam int FRAC_BITS = 16;
   localparam int SCALE_BITS = 16;
   localparam int SQ_W = 64;
   localparam int RES_W = 98;
   localparam int ACC_W = 80;
   localparam int SCALE_PROD_W = FIELD_W + SCALE_BITS;
   localparam int CUR_PROD_W = 2 * FIELD_W;
   localparam logic [FIELD_W-1:0] INV_TS_RESET = 32'd145636;

   typedef struct packed {
      logic signed [FIELD_W-1:0] e_x;
      logic signed [FIELD_W-1:0] e_y;
      logic signed [FIELD_W-1:0] e_z;
      logic signed [FIELD_W-1:0] b_x;
      logic signed [FIELD_W-1:0] b_y;
      logic signed [FIELD_W-1:0] b_z;
   } ffelim_req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] new_e_x;
      logic signed [FIELD_W-1:0] new_e_y;
      logic signed [FIELD_W-1:0] new_e_z;
      logic signed [FIELD_W-1:0] cur_add_x;
      logic signed [FIELD_W-1:0] cur_add_y;
      logic signed [FIELD_W-1:0] cur_add_z;
      logic                      was_limited;
      logic                      saturated;
   } ffelim_rsp_type;

   // absolute value; the most negative value maps to 2^31 as unsigned
   function automatic logic [FIELD_W-1:0] mag(input logic signed [FIELD_W-1:0] v);
      mag = v[FIELD_W-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

### rtl/ffe_efield_magnitude_limiter_unit.sv
// Force-free E-field limiter: scales E down to |B| and reports the current increment.
// Depends on ffelim_pkg (payload structs, widths, reset value of the step register).
//
//  channel | ports                         | direction | payload
//  req     | req_valid req_stall req_data  | in        | ffelim_req_type
//  rsp     | rsp_valid rsp_stall rsp_data  | out       | ffelim_rsp_type
//  csr     | csr_wr_en csr_wr_data         | in        | inv_time_step, Q16.16
//
// One transaction per cycle while req_stall is low; squares and sums feed the 16-stage
// bit-serial scale search (one result bit per stage), then the scaling multiplies.
// Synchronous active-high reset clears valid bits; the step register resets to 145636.
// A two-entry output (register plus skid) lets the pipeline keep flowing under rsp_stall
// until the skid entry fills; req_stall rises only when the skid entry is occupied.
module ffe_efield_magnitude_limiter_unit (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  ffelim_pkg::ffelim_req_type                  req_data,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output ffelim_pkg::ffelim_rsp_type                  rsp_data,
   input  logic                                        csr_wr_en,
   input  logic [ffelim_pkg::FIELD_W-1:0]              csr_wr_data
);

   localparam int W = ffelim_pkg::FIELD_W;
   localparam int NSTEP = ffelim_pkg::SCALE_BITS;

   logic [W-1:0] inv_ts_ff;
   logic         ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ts_ff <= ffelim_pkg::INV_TS_RESET;
      end else if (csr_wr_en) begin
         inv_ts_ff <= csr_wr_data;
      end
   end

   // ---------------- stage 1: squares
   logic signed [W-1:0] e_in [3];
   logic signed [W-1:0] b_in [3];
   assign e_in[0] = req_data.e_x;
   assign e_in[1] = req_data.e_y;
   assign e_in[2] = req_data.e_z;
   assign b_in[0] = req_data.b_x;
   assign b_in[1] = req_data.b_y;
   assign b_in[2] = req_data.b_z;

   logic                          s1_valid_ff;
   logic signed [W-1:0]           s1_e_ff   [3];
   logic [ffelim_pkg::SQ_W-1:0]   s1_esq_ff [3];
   logic [ffelim_pkg::SQ_W-1:0]   s1_bsq_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ce) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int c = 0; c < 3; c++) begin
            s1_e_ff[c]   <= e_in[c];
            s1_esq_ff[c] <= ffelim_pkg::mag(e_in[c]) * ffelim_pkg::mag(e_in[c]);
            s1_bsq_ff[c] <= ffelim_pkg::mag(b_in[c]) * ffelim_pkg::mag(b_in[c]);
         end
      end
   end

   // ---------------- stage 2: sums of squares
   logic                          s2_valid_ff;
   logic signed [W-1:0]           s2_e_ff [3];
   logic [ffelim_pkg::SQ_W-1:0]   s2_e2_ff;
   logic [ffelim_pkg::SQ_W-1:0]   s2_b2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ce) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s2_e_ff  <= s1_e_ff;
         s2_e2_ff <= s1_esq_ff[0] + s1_esq_ff[1] + s1_esq_ff[2];
         s2_b2_ff <= s1_bsq_ff[0] + s1_bsq_ff[1] + s1_bsq_ff[2];
      end
   end

   // ---------------- scale search: st index 0 is the seed, 1..NSTEP after each bit
   logic                             st_valid_ff [NSTEP+1];
   logic signed [W-1:0]              st_e_ff     [NSTEP+1][3];
   logic                             st_lim_ff   [NSTEP+1];
   logic [ffelim_pkg::SQ_W-1:0]      st_e2_ff    [NSTEP+1];
   logic [ffelim_pkg::RES_W-1:0]     st_r_ff     [NSTEP+1];
   logic [ffelim_pkg::ACC_W-1:0]     st_t_ff     [NSTEP+1];
   logic [NSTEP-1:0]                 st_s_ff     [NSTEP+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff[0] <= 1'b0;
      end else if (ce) begin
         st_valid_ff[0] <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         st_e_ff[0]  <= s2_e_ff;
         st_lim_ff[0] <= s2_b2_ff < s2_e2_ff;
         st_e2_ff[0] <= s2_e2_ff;
         st_r_ff[0]  <= {2'b00, s2_b2_ff, 32'd0};
         st_t_ff[0]  <= '0;
         st_s_ff[0]  <= '0;
      end
   end

   // residual R = B2*2^32 - s^2*E2, T = s*E2; trying bit k costs (T<<(k+1)) + (E2<<2k)
   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      localparam int K = NSTEP - 1 - i;
      logic [ffelim_pkg::RES_W-1:0] inc;
      logic                         take_bit;

      assign inc = ({{(ffelim_pkg::RES_W-ffelim_pkg::ACC_W){1'b0}}, st_t_ff[i]} << (K + 1))
                 + ({{(ffelim_pkg::RES_W-ffelim_pkg::SQ_W){1'b0}}, st_e2_ff[i]} << (2 * K));
      assign take_bit = st_r_ff[i] >= inc;

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[i+1] <= 1'b0;
         end else if (ce) begin
            st_valid_ff[i+1] <= st_valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            st_e_ff[i+1]   <= st_e_ff[i];
            st_lim_ff[i+1] <= st_lim_ff[i];
            st_e2_ff[i+1]  <= st_e2_ff[i];
            if (take_bit) begin
               st_r_ff[i+1] <= st_r_ff[i] - inc;
               st_t_ff[i+1] <= st_t_ff[i]
                  + ({{(ffelim_pkg::ACC_W-ffelim_pkg::SQ_W){1'b0}}, st_e2_ff[i]} << K);
               st_s_ff[i+1] <= st_s_ff[i] | (NSTEP'(1) << K);
            end else begin
               st_r_ff[i+1] <= st_r_ff[i];
               st_t_ff[i+1] <= st_t_ff[i];
               st_s_ff[i+1] <= st_s_ff[i];
            end
         end
      end
   end

   // ---------------- m1: |e| * s
   logic                                  m1_valid_ff;
   logic signed [W-1:0]                   m1_e_ff    [3];
   logic                                  m1_lim_ff;
   logic [ffelim_pkg::SCALE_PROD_W-1:0]   m1_prod_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (ce) begin
         m1_valid_ff <= st_valid_ff[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         m1_e_ff   <= st_e_ff[NSTEP];
         m1_lim_ff <= st_lim_ff[NSTEP];
         for (int c = 0; c < 3; c++) begin
            m1_prod_ff[c] <= ffelim_pkg::mag(st_e_ff[NSTEP][c]) * st_s_ff[NSTEP];
         end
      end
   end

   // ---------------- m2: limited field and dissipated magnitude
   logic                  m2_valid_ff;
   logic signed [W-1:0]   m2_e_ff  [3];
   logic                  m2_lim_ff;
   logic signed [W-1:0]   m2_ne_ff [3];
   logic [W-1:0]          m2_d_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (ce) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         m2_e_ff   <= m1_e_ff;
         m2_lim_ff <= m1_lim_ff;
         for (int c = 0; c < 3; c++) begin
            m2_ne_ff[c] <= m1_e_ff[c][W-1] ? -$signed(m1_prod_ff[c][ffelim_pkg::FRAC_BITS +: W])
                                           : $signed(m1_prod_ff[c][ffelim_pkg::FRAC_BITS +: W]);
            m2_d_ff[c]  <= ffelim_pkg::mag(m1_e_ff[c])
                         - m1_prod_ff[c][ffelim_pkg::FRAC_BITS +: W];
         end
      end
   end

   // ---------------- m3: dissipated magnitude times inverse step
   logic                                 m3_valid_ff;
   logic signed [W-1:0]                  m3_e_ff   [3];
   logic                                 m3_lim_ff;
   logic signed [W-1:0]                  m3_ne_ff  [3];
   logic [ffelim_pkg::CUR_PROD_W-1:0]    m3_cur_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff <= 1'b0;
      end else if (ce) begin
         m3_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         m3_e_ff   <= m2_e_ff;
         m3_lim_ff <= m2_lim_ff;
         m3_ne_ff  <= m2_ne_ff;
         for (int c = 0; c < 3; c++) begin
            m3_cur_ff[c] <= m2_d_ff[c] * inv_ts_ff;
         end
      end
   end

   // ---------------- final: sign, saturate, select pass-through
   localparam int CQ_W = ffelim_pkg::CUR_PROD_W - ffelim_pkg::FRAC_BITS;
   logic [CQ_W-1:0]      cq    [3];
   logic signed [W-1:0]  cur   [3];
   logic                 clip  [3];
   ffelim_pkg::ffelim_rsp_type fin;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         cq[c] = m3_cur_ff[c][ffelim_pkg::FRAC_BITS +: CQ_W];
         if (m3_e_ff[c][W-1]) begin
            clip[c] = cq[c] > CQ_W'(33'h1_0000_0000 >> 1);
            cur[c]  = clip[c] ? $signed({1'b1, {(W-1){1'b0}}}) : -$signed(cq[c][W-1:0]);
         end else begin
            clip[c] = cq[c] > CQ_W'({1'b0, {(W-1){1'b1}}});
            cur[c]  = clip[c] ? $signed({1'b0, {(W-1){1'b1}}}) : $signed(cq[c][W-1:0]);
         end
      end
      fin.was_limited = m3_lim_ff;
      if (m3_lim_ff) begin
         fin.new_e_x   = m3_ne_ff[0];
         fin.new_e_y   = m3_ne_ff[1];
         fin.new_e_z   = m3_ne_ff[2];
         fin.cur_add_x = cur[0];
         fin.cur_add_y = cur[1];
         fin.cur_add_z = cur[2];
         fin.saturated = clip[0] | clip[1] | clip[2];
      end else begin
         fin.new_e_x   = m3_e_ff[0];
         fin.new_e_y   = m3_e_ff[1];
         fin.new_e_z   = m3_e_ff[2];
         fin.cur_add_x = '0;
         fin.cur_add_y = '0;
         fin.cur_add_z = '0;
         fin.saturated = 1'b0;
      end
   end

   // ---------------- output register and skid entry
   logic                       out_valid_ff;
   ffelim_pkg::ffelim_rsp_type out_data_ff;
   logic                       skid_valid_ff;
   ffelim_pkg::ffelim_rsp_type skid_data_ff;
   logic                       take;

   assign take = out_valid_ff && !rsp_stall;
   assign ce   = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_ff <= m3_valid_ff;
      end else if (m3_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || take) begin
         out_data_ff <= fin;
      end else begin
         skid_data_ff <= fin;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign req_stall = skid_valid_ff;

endmodule

### rtl/ffelim_port_checker.sv
// Port-level checks for the E-field limiter, bound to its top level.
// Depends on ffelim_pkg and ffe_efield_magnitude_limiter_unit.
module ffelim_port_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input ffelim_pkg::ffelim_rsp_type rsp_data
);

   // input backs up only behind a waiting result
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && $past(rsp_stall))
      else $error("req_stall without a blocked result");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_pass_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.was_limited |->
         rsp_data.cur_add_x == '0 && rsp_data.cur_add_y == '0 &&
         rsp_data.cur_add_z == '0 && !rsp_data.saturated)
      else $error("unlimited transaction carries current");

   a_sat_limited: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> rsp_data.was_limited)
      else $error("saturation flagged on unlimited transaction");

endmodule

bind ffe_efield_magnitude_limiter_unit ffelim_port_checker u_ffelim_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
